// ===== src/mma_pkg.sv =====
// Package for the multichannel moving average unit.
// Holds sizes, fixed-point constants, status codes and the queue item type.
// No dependencies; every other file imports it.
package mma_pkg;

    localparam int CHANNELS = 3;
    localparam int WINDOW   = 10;

    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 12;
    localparam int MEAN_W     = 12;
    localparam int MV_W       = 12;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = 16;
    localparam int CHAN_CMP_W = CHAN_W + 1;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SLOTS    = CHANNELS * WINDOW;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int DIV_SHIFT  = 20;
    localparam int RECIP_W    = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((1 << DIV_SHIFT) / WINDOW);
    localparam int DIV_PROD_W = SUM_W + RECIP_W;

    localparam int MV_SCALE   = 3300;
    localparam int MV_SCALE_W = 12;
    localparam int MV_SHIFT   = 12;
    localparam int MV_PROD_W  = MEAN_W + MV_SCALE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_READ_FAILED = 2'd2
    } status_t;

    typedef struct packed {
        status_t               status;
        logic [CH_IDX_W-1:0]   ch;
        logic [SLOT_W-1:0]     base;
        logic [SAMPLE_W-1:0]   sample;
    } mma_item_t;

endpackage

// ===== src/mma_if.sv =====
// Channel interfaces: converter samples in, averaged results out.
// Depends on mma_pkg for field widths.
interface mma_adc_if import mma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                read_failed;

    modport source (output valid, channel, sample, read_failed, input ready);
    modport sink   (input valid, channel, sample, read_failed, output ready);
endinterface

interface mma_avg_if import mma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MEAN_W-1:0]   mean_code;
    logic [MV_W-1:0]     millivolts;
    logic [STATUS_W-1:0] status;

    modport source (output valid, mean_code, millivolts, status, input ready);
    modport sink   (input valid, mean_code, millivolts, status, output ready);
endinterface

// ===== src/mma_front.sv =====
// Front end: accepts converter beats, checks channel and read flag,
// and forms the queue item with the channel's ring base. Uses mma_pkg.
module mma_front import mma_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    mma_adc_if.sink       adc,
    output logic          push_valid,
    input  logic          push_ready,
    output mma_item_t     push_item
);

    logic      valid_reg;
    logic      valid_next;
    mma_item_t item_reg;
    mma_item_t item_next;
    logic      take;
    logic      bad_channel;

    assign adc.ready   = !valid_reg || push_ready;
    assign take        = adc.valid && adc.ready;
    assign bad_channel = CHAN_CMP_W'(adc.channel) >= CHAN_CMP_W'(CHANNELS);

    always_comb
    begin
        item_next        = item_reg;
        valid_next       = valid_reg;
        if (take)
        begin
            valid_next       = 1'b1;
            item_next.sample = adc.sample;
            if (bad_channel)
            begin
                item_next.status = ST_BAD_CHANNEL;
                item_next.ch     = '0;
                item_next.base   = '0;
            end
            else
            begin
                item_next.status = adc.read_failed ? ST_READ_FAILED : ST_OK;
                item_next.ch     = adc.channel[CH_IDX_W-1:0];
                item_next.base   = SLOT_W'(adc.channel[CH_IDX_W-1:0]) * SLOT_W'(WINDOW);
            end
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// ===== src/mma_queue.sv =====
// Short FIFO between front and back ends so each side stalls on its own.
// Depends on mma_pkg for the item type and depth.
module mma_queue import mma_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  mma_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output mma_item_t pop_item
);

    mma_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mma_back.sv =====
// Back end: ring update with running sum, divide by the window through a
// reciprocal multiply, millivolt scaling and the output register. Uses mma_pkg.
module mma_back import mma_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  mma_item_t pop_item,
    mma_avg_if.source avg
);

    logic [SAMPLE_W-1:0] store_reg [SLOTS];
    logic [SUM_W-1:0]    sum_reg   [CHANNELS];
    logic [POS_W-1:0]    pos_reg   [CHANNELS];

    logic                adv;
    logic                write_en;
    logic [POS_W-1:0]    pos_cur;
    logic [POS_W-1:0]    pos_next;
    logic [SLOT_W-1:0]   slot;
    logic [SUM_W-1:0]    sum_next;

    logic                a_valid_reg;
    status_t             a_status_reg;
    logic [SUM_W-1:0]    a_sum_reg;

    logic                b_valid_reg;
    status_t             b_status_reg;
    logic [SUM_W-1:0]    b_sum_reg;
    logic [DIV_PROD_W-1:0] b_prod_reg;
    logic [DIV_PROD_W-1:0] b_prod_next;

    logic                c_valid_reg;
    status_t             c_status_reg;
    logic [MEAN_W-1:0]   c_mean_reg;
    logic [MEAN_W-1:0]   c_mean_next;
    logic [SUM_W-1:0]    quot_est;
    logic [SUM_W-1:0]    rem;

    logic                d_valid_reg;
    status_t             d_status_reg;
    logic [MEAN_W-1:0]   d_mean_reg;
    logic [MV_PROD_W-1:0] d_mvprod_reg;
    logic [MV_PROD_W-1:0] d_mvprod_next;

    logic                out_valid_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [MEAN_W-1:0]   mean_next;
    logic [MV_W-1:0]     mv_reg;
    logic [MV_W-1:0]     mv_next;
    status_t             status_reg;

    // advance the whole pipe unless the result register is held
    assign adv       = !out_valid_reg || avg.ready;
    assign pop_ready = adv;
    assign write_en  = adv && pop_valid && (pop_item.status == ST_OK);

    always_comb
    begin
        pos_cur  = pos_reg[pop_item.ch];
        pos_next = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;
        slot     = pop_item.base + SLOT_W'(pos_cur);
        sum_next = sum_reg[pop_item.ch] - SUM_W'(store_reg[slot])
                 + SUM_W'(pop_item.sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                store_reg[i] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
                pos_reg[c] <= '0;
            end
        end
        else if (write_en)
        begin
            store_reg[slot]       <= pop_item.sample;
            sum_reg[pop_item.ch]  <= sum_next;
            pos_reg[pop_item.ch]  <= pos_next;
        end
    end

    always_comb
    begin
        b_prod_next   = DIV_PROD_W'(a_sum_reg) * DIV_PROD_W'(DIV_RECIP);
        quot_est      = b_prod_reg[DIV_SHIFT +: SUM_W];
        rem           = b_sum_reg - SUM_W'(quot_est * SUM_W'(WINDOW));
        c_mean_next   = (rem >= SUM_W'(WINDOW)) ? MEAN_W'(quot_est + 1'b1)
                                                : MEAN_W'(quot_est);
        d_mvprod_next = MV_PROD_W'(c_mean_reg) * MV_PROD_W'(MV_SCALE);
        // drop values of failed items
        mean_next     = (d_status_reg == ST_OK) ? d_mean_reg : '0;
        mv_next       = (d_status_reg == ST_OK) ? d_mvprod_reg[MV_SHIFT +: MV_W] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= pop_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_status_reg <= pop_item.status;
            a_sum_reg    <= sum_next;
            b_status_reg <= a_status_reg;
            b_sum_reg    <= a_sum_reg;
            b_prod_reg   <= b_prod_next;
            c_status_reg <= b_status_reg;
            c_mean_reg   <= c_mean_next;
            d_status_reg <= c_status_reg;
            d_mean_reg   <= c_mean_reg;
            d_mvprod_reg <= d_mvprod_next;
            status_reg   <= d_status_reg;
            mean_reg     <= mean_next;
            mv_reg       <= mv_next;
        end
    end

    assign avg.valid      = out_valid_reg;
    assign avg.mean_code  = mean_reg;
    assign avg.millivolts = mv_reg;
    assign avg.status     = status_reg;

endmodule

// ===== src/multichannel_moving_average_unit.sv =====
// Top level of the multichannel moving average unit.
// Depends on mma_pkg, mma_if, mma_front, mma_queue and mma_back.
//
// Usage:
//   adc: one beat per converter reading (channel, sample, read_failed).
//   avg: one beat per input beat, in order (mean_code, millivolts, status).
//   Each good reading on a valid channel replaces the oldest entry of that
//   channel's ring of WINDOW samples and updates its running sum; the result
//   is the truncated window mean and floor(mean * 3300 / 4096).
//   A channel at or above CHANNELS returns status 1, a failed read status 2;
//   both return zero values and leave all state untouched.
// Timing:
//   Throughput is one beat per cycle while avg is not held, set by the ring
//   and sum update in the back end. Beats pass from adc accept to avg valid
//   through the front register, queue, ring update, reciprocal multiply,
//   correction, millivolt multiply and the result register.
// Reset:
//   Clears all rings, sums and ring positions at once; means taken before a
//   window fills include those zeros.
// Stall:
//   A held avg beat freezes the back pipe; the 4-entry queue and the front
//   register then absorb beats until adc.ready drops.
module multichannel_moving_average_unit import mma_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    mma_adc_if.sink   adc,
    mma_avg_if.source avg
);

    logic      push_valid;
    logic      push_ready;
    mma_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    mma_item_t pop_item;

    mma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adc        (adc),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mma_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .avg        (avg)
    );

endmodule
